### rtl/lfd_pkg.sv
`default_nettype none

package lfd_pkg;

	// Frame buffer holds positions 1 to BUF_DEPTH of a frame.
	localparam int BUF_DEPTH = 14;

	// The back end only needs positions 3 to 14.
	localparam int PAYLOAD_FIRST = 3;
	localparam int PAYLOAD_BYTES = BUF_DEPTH - PAYLOAD_FIRST + 1;

	// Command queue between the front and back ends.
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Identifier codes.
	localparam logic [7:0] SYS_VIDEO  = 8'd2;
	localparam logic [7:0] SYS_BUS    = 8'd1;
	localparam logic [7:0] CMD_TIMING = 8'd3;
	localparam logic [7:0] CMD_SERIAL = 8'd1;
	localparam logic [7:0] CMD_BUS    = 8'd1;

	// Shortest lengths that carry the bytes a message type needs.
	localparam logic [7:0] MIN_LEN_IDS    = 8'd3;
	localparam logic [7:0] MIN_LEN_TIMING = 8'd15;
	localparam logic [7:0] MIN_LEN_SHORT  = 8'd9;

	// Lengths at or below this end the frame on the length byte itself.
	localparam logic [7:0] MAX_EMPTY_LEN = 8'd1;

	typedef enum logic [1:0] {
		FT_NONE   = 2'd0,
		FT_TIMING = 2'd1,
		FT_SERIAL = 2'd2,
		FT_BUS    = 2'd3
	} frame_type_t;

	typedef logic [PAYLOAD_BYTES-1:0][7:0] payload_t;

	typedef struct packed {
		frame_type_t ftype;
		payload_t    data;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/lfd_if.sv
`default_nettype none

interface lfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_type;
	logic [15:0] width;
	logic [15:0] height;
	logic [15:0] vsync_len;
	logic [15:0] hsync_len;
	logic [15:0] blank_v;
	logic [15:0] blank_h;
	logic [7:0]  video_format;
	logic [7:0]  frame_format;
	logic [39:0] bus_settings;
	logic        timing_available;
	logic        serial_available;

	modport source (
		output valid, output frame_type, output width, output height,
		output vsync_len, output hsync_len, output blank_v, output blank_h,
		output video_format, output frame_format, output bus_settings,
		output timing_available, output serial_available,
		input ready
	);
	modport sink (
		input valid, input frame_type, input width, input height,
		input vsync_len, input hsync_len, input blank_v, input blank_h,
		input video_format, input frame_format, input bus_settings,
		input timing_available, input serial_available,
		output ready
	);
endinterface

`default_nettype wire

### rtl/lfd_front.sv
`default_nettype none

module lfd_front
	import lfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	lfd_rx_if.sink    rx,
	output logic      push_valid,
	input  wire logic push_ready,
	output cmd_t      push_data
);

	logic [7:0]                pos_q;
	logic [7:0]                len_q;
	logic [BUF_DEPTH-1:0][7:0] buf_q;

	logic                      acc;
	logic [7:0]                pos_next;
	logic                      frame_end;
	logic [BUF_DEPTH-1:0][7:0] merged;
	frame_type_t               ftype;

	assign rx.ready = push_ready;
	assign acc      = rx.valid && push_ready;
	assign pos_next = pos_q + 8'd1;

	// A frame ends either on a length byte of zero or one, or on its last byte.
	assign frame_end = (pos_q == 8'd0) ? (rx.rx_byte <= MAX_EMPTY_LEN) : (pos_next >= len_q);

	// The buffer as it stands once the current item is written.
	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++) begin
			merged[i] = (pos_q == 8'(i + 1)) ? rx.rx_byte : buf_q[i];
		end
	end

	always_comb begin
		ftype = FT_NONE;
		if (pos_q != 8'd0 && len_q >= MIN_LEN_IDS) begin
			if (merged[0] == SYS_VIDEO && merged[1] == CMD_TIMING) begin
				if (len_q >= MIN_LEN_TIMING) begin
					ftype = FT_TIMING;
				end
			end else if (merged[0] == SYS_VIDEO && merged[1] == CMD_SERIAL) begin
				if (len_q >= MIN_LEN_SHORT) begin
					ftype = FT_SERIAL;
				end
			end else if (merged[0] == SYS_BUS && merged[1] == CMD_BUS) begin
				if (len_q >= MIN_LEN_SHORT) begin
					ftype = FT_BUS;
				end
			end
		end
	end

	always_comb begin
		push_valid      = acc && frame_end;
		push_data.ftype = ftype;
		for (int k = 0; k < PAYLOAD_BYTES; k++) begin
			push_data.data[k] = merged[k + PAYLOAD_FIRST - 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 8'd0;
			len_q <= 8'd0;
		end else if (acc) begin
			if (pos_q == 8'd0) begin
				if (!frame_end) begin
					len_q <= rx.rx_byte;
					pos_q <= 8'd1;
				end
			end else if (frame_end) begin
				pos_q <= 8'd0;
			end else begin
				pos_q <= pos_next;
			end
		end
	end

	// Bytes past the buffer are counted but not kept.
	always_ff @(posedge clk) begin
		if (acc && pos_q != 8'd0) begin
			buf_q <= merged;
		end
	end

endmodule

`default_nettype wire

### rtl/lfd_queue.sv
`default_nettype none

module lfd_queue
	import lfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cmd_t push_data,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cmd_t      pop_data
);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### rtl/lfd_back.sv
`default_nettype none

module lfd_back
	import lfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	output logic      pop_ready,
	input  wire cmd_t pop_data,
	lfd_res_if.source result
);

	logic        valid_q;
	frame_type_t type_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [15:0] vsync_q;
	logic [15:0] hsync_q;
	logic [15:0] blank_v_q;
	logic [15:0] blank_h_q;
	logic [7:0]  video_format_q;
	logic [7:0]  frame_format_q;
	logic [39:0] bus_q;
	logic        timing_avail_q;
	logic        serial_avail_q;
	logic        pop;
	payload_t    d;

	assign pop_ready = !valid_q || result.ready;
	assign pop       = pop_valid && pop_ready;
	assign d         = pop_data.data;

	// The stored record doubles as the output register, so it only moves when
	// the previous item has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= 1'b0;
			type_q         <= FT_NONE;
			width_q        <= '0;
			height_q       <= '0;
			vsync_q        <= '0;
			hsync_q        <= '0;
			blank_v_q      <= '0;
			blank_h_q      <= '0;
			video_format_q <= '0;
			frame_format_q <= '0;
			bus_q          <= '0;
			timing_avail_q <= 1'b0;
			serial_avail_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
			type_q  <= pop_data.ftype;
			unique case (pop_data.ftype)
				FT_TIMING: begin
					width_q        <= {d[0], d[1]};
					height_q       <= {d[2], d[3]};
					vsync_q        <= {d[4], d[5]};
					hsync_q        <= {d[6], d[7]};
					blank_v_q      <= {d[8], d[9]};
					blank_h_q      <= {d[10], d[11]};
					timing_avail_q <= 1'b1;
				end
				FT_SERIAL: begin
					video_format_q <= d[0];
					frame_format_q <= d[1];
					blank_h_q      <= {d[2], d[3]};
					blank_v_q      <= {d[4], d[5]};
					serial_avail_q <= 1'b1;
				end
				// Position 3 is skipped in a bus settings frame.
				FT_BUS: begin
					bus_q <= {d[1], d[2], d[3], d[4], d[5]};
				end
				FT_NONE: begin
				end
				default: begin
				end
			endcase
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign result.valid            = valid_q;
	assign result.frame_type       = type_q;
	assign result.width            = width_q;
	assign result.height           = height_q;
	assign result.vsync_len        = vsync_q;
	assign result.hsync_len        = hsync_q;
	assign result.blank_v          = blank_v_q;
	assign result.blank_h          = blank_h_q;
	assign result.video_format     = video_format_q;
	assign result.frame_format     = frame_format_q;
	assign result.bus_settings     = bus_q;
	assign result.timing_available = timing_avail_q;
	assign result.serial_available = serial_avail_q;

endmodule

`default_nettype wire

### rtl/length_prefixed_frame_decoder_unit.sv
// Length-prefixed frame decoder.
// The rx channel takes one link byte per item. The first byte of a frame is
// its total length, counting the length byte itself; bytes at positions 1 to
// 14 are kept, later ones are only counted. Positions 1 and 2 select the
// message type, which updates the stored video timing, serial video or bus
// settings fields.
// The result channel gives one item per frame: the frame type and the whole
// stored record. A length byte of zero or one is a frame by itself.
// Throughput is one byte per cycle while the command queue has room, frames of
// any length back to back. The last byte of a frame is classified as it is
// accepted and queued; the result becomes valid once that command has left the
// queue and the back end has applied it to the record.
// When the result receiver stalls, the held result waits in the output
// register and the two-entry command queue absorbs up to two more frame ends;
// rx.ready drops only when that queue is full.
// Reset clears the byte counter, the queue and the stored record to zero.

`default_nettype none

module length_prefixed_frame_decoder_unit
	import lfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	lfd_rx_if.sink    rx,
	lfd_res_if.source result
);

	logic push_valid;
	logic push_ready;
	cmd_t push_data;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_data;

	lfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	lfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule

`default_nettype wire

### rtl/lfd_checker.sv
`default_nettype none

module lfd_checker
	import lfd_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [1:0]  frame_type,
	input wire logic [39:0] bus_settings,
	input wire logic        timing_available,
	input wire logic        serial_available
);

	// A stalled result holds its type and bus record.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(frame_type) && $stable(bus_settings))
		else $error("result changed while stalled");

	// The availability flags never clear once set.
	a_timing_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		timing_available |=> timing_available)
		else $error("timing_available dropped");

	a_serial_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		serial_available |=> serial_available)
		else $error("serial_available dropped");

	// A reported video frame must already show up in the flags.
	a_timing_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_type == FT_TIMING |-> timing_available)
		else $error("timing frame without timing_available");

	a_serial_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_type == FT_SERIAL |-> serial_available)
		else $error("serial frame without serial_available");

endmodule

bind length_prefixed_frame_decoder_unit lfd_checker u_lfd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.frame_type       (result.frame_type),
	.bus_settings     (result.bus_settings),
	.timing_available (result.timing_available),
	.serial_available (result.serial_available)
);

`default_nettype wire
